/* hw/rtl/sha256_hash_top_assert.svh */
// Assertion macros for the checker file of the hash block.
// Each macro expands to one labeled concurrent assertion that is disabled
// while the synchronous reset is held low.
`ifndef SHA256_HASH_TOP_ASSERT_SVH
`define SHA256_HASH_TOP_ASSERT_SVH

// Same-cycle implication.
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sha_pkg.sv */
package sha_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NUM_VARS = 8;
    localparam int unsigned NUM_SCHED = 16;
    localparam int unsigned NUM_ROUNDS = 64;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [NUM_VARS-1:0][WORD_W-1:0] t_hash;
    typedef logic [NUM_SCHED-1:0][WORD_W-1:0] t_sched;

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  valid_bytes;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] hash_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Control from the padding sequencer to the compression engine.
    typedef struct packed {
        logic  push;
        logic  start;
        t_word word;
    } t_core_ctl;

    localparam t_hash HASH_IV = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    localparam t_word ROUND_K [NUM_ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

endpackage

/* hw/rtl/sha_core.sv */
module sha_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_core_ctl i_ctl,
    input  sha_pkg::t_hash    i_chain,
    output logic              o_done,
    output sha_pkg::t_hash    o_vars
);
    import sha_pkg::*;

    localparam logic [5:0] RND_LAST = 6'(NUM_ROUNDS - 1);

    // The schedule window doubles as the block buffer: words shift in at the
    // top, so after sixteen pushes the oldest word sits in entry zero.
    t_sched     r_w, n_w;
    t_hash      r_v, n_v;
    logic       r_run, n_run;
    logic       r_done, n_done;
    logic [5:0] r_rnd, n_rnd;

    t_word w_t1, w_t2, w_new;
    t_word a, b, c, e, f, g, h;
    t_word x1, x14;

    always_comb begin
        a   = r_v[0];
        b   = r_v[1];
        c   = r_v[2];
        e   = r_v[4];
        f   = r_v[5];
        g   = r_v[6];
        h   = r_v[7];
        x1  = r_w[1];
        x14 = r_w[14];

        w_t1 = h
             + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
             + ((e & f) | (~e & g))
             + ROUND_K[r_rnd]
             + r_w[0];
        w_t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
             + ((a & b) | (a & c) | (b & c));

        w_new = ({x14[16:0], x14[31:17]} ^ {x14[18:0], x14[31:19]} ^ (x14 >> 10))
              + r_w[9]
              + ({x1[6:0], x1[31:7]} ^ {x1[17:0], x1[31:18]} ^ (x1 >> 3))
              + r_w[0];
    end

    always_comb begin
        n_w    = r_w;
        n_v    = r_v;
        n_run  = r_run;
        n_rnd  = r_rnd;
        n_done = 1'b0;

        if (i_ctl.push) begin
            n_w = {i_ctl.word, r_w[NUM_SCHED-1:1]};
        end else if (r_run) begin
            n_w = {w_new, r_w[NUM_SCHED-1:1]};
        end

        if (i_ctl.start) begin
            n_v   = i_chain;
            n_run = 1'b1;
            n_rnd = '0;
        end else if (r_run) begin
            n_v[7] = g;
            n_v[6] = f;
            n_v[5] = e;
            n_v[4] = r_v[3] + w_t1;
            n_v[3] = c;
            n_v[2] = b;
            n_v[1] = a;
            n_v[0] = w_t1 + w_t2;
            n_rnd  = r_rnd + 6'd1;
            if (r_rnd == RND_LAST) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_v <= n_v;
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_rnd  <= n_rnd;
        end
    end

    assign o_done = r_done;
    assign o_vars = r_v;

endmodule

/* hw/rtl/sha256_hash_top.sv */
// Message words are taken back to back while the sequencer waits for words; every
// sixteenth word stalls the input for the 64 compression rounds, one round per cycle in
// the shared round unit. A last item is followed by padding and final compressions, then
// eight digest transfers, one per cycle when the output side does not stall.
// Reset (synchronous, active low) loads the initial hash and clears all counts.
module sha256_hash_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sha_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sha_pkg::t_out_item o_out_item
);
    import sha_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;  // taking message words
    localparam logic [2:0] S_PAD  = 3'd1;  // pushing the stand-alone pad word
    localparam logic [2:0] S_ZERO = 3'd2;  // zero fill, then the length high word
    localparam logic [2:0] S_LO   = 3'd3;  // pushing the length low word
    localparam logic [2:0] S_COMP = 3'd4;  // waiting on the round unit
    localparam logic [2:0] S_OUT  = 3'd5;  // sending the digest words

    localparam logic [3:0] POS_LAST   = 4'd15;
    localparam logic [3:0] POS_LENGTH = 4'd14;
    localparam logic [2:0] BYTES_FULL = 3'd4;
    localparam logic [2:0] IDX_LAST   = 3'd7;
    localparam t_word      PAD_WORD   = 32'h8000_0000;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_ret, n_ret;
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_cnt, n_cnt;
    t_hash       r_h, n_h;
    logic        r_ovld, n_ovld;
    logic [2:0]  r_oidx, n_oidx;
    t_out_item   r_out, n_out;

    t_core_ctl   w_ctl;
    logic        w_done;
    t_hash       w_vars;
    logic [2:0]  w_after;
    logic [2:0]  w_vb;
    t_word       w_tail;

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_chain (r_h),
        .o_done  (w_done),
        .o_vars  (w_vars)
    );

    // On the last item only the leading valid bytes are kept, and the pad
    // byte lands directly behind them. Counts above four mean a full word.
    always_comb begin
        w_vb = (i_in_item.valid_bytes > BYTES_FULL) ? BYTES_FULL : i_in_item.valid_bytes;
        case (w_vb)
            3'd0:    w_tail = PAD_WORD;
            3'd1:    w_tail = {i_in_item.msg_word[31:24], 24'h80_0000};
            3'd2:    w_tail = {i_in_item.msg_word[31:16], 16'h8000};
            3'd3:    w_tail = {i_in_item.msg_word[31:8], 8'h80};
            default: w_tail = i_in_item.msg_word;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_h     = r_h;
        n_ovld  = r_ovld;
        n_oidx  = r_oidx;
        n_out   = r_out;
        w_ctl   = '0;
        w_after = r_state;

        // The output register empties when its word is transferred.
        if (r_ovld && !i_out_stall) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.push = 1'b1;
                    if (!i_in_item.last) begin
                        w_ctl.word = i_in_item.msg_word;
                        n_cnt      = r_cnt + 32'(BYTES_FULL);
                        w_after    = S_IDLE;
                    end else begin
                        // A full last word still needs a separate pad word.
                        w_ctl.word = w_tail;
                        n_cnt      = r_cnt + 32'(w_vb);
                        w_after    = (w_vb == BYTES_FULL) ? S_PAD : S_ZERO;
                    end
                end
            end
            S_PAD: begin
                w_ctl.push = 1'b1;
                w_ctl.word = PAD_WORD;
                w_after    = S_ZERO;
            end
            S_ZERO: begin
                // Fill with zeros up to the length slot; a block with no room
                // left is padded out, compressed, and the next one filled.
                w_ctl.push = 1'b1;
                if (r_pos == POS_LENGTH) begin
                    w_ctl.word = {29'd0, r_cnt[31:29]};
                    w_after    = S_LO;
                end else begin
                    w_ctl.word = '0;
                    w_after    = S_ZERO;
                end
            end
            S_LO: begin
                w_ctl.push = 1'b1;
                w_ctl.word = {r_cnt[28:0], 3'd0};
                w_after    = S_OUT;
            end
            S_COMP: begin
                if (w_done) begin
                    for (int i = 0; i < NUM_VARS; i++) begin
                        n_h[i] = r_h[i] + w_vars[i];
                    end
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (!r_ovld || !i_out_stall) begin
                    n_ovld           = 1'b1;
                    n_out.hash_word  = r_h[r_oidx];
                    n_out.word_index = r_oidx;
                    n_out.last_word  = (r_oidx == IDX_LAST);
                    n_oidx           = r_oidx + 3'd1;
                    if (r_oidx == IDX_LAST) begin
                        // Digest captured: start over for the next message.
                        n_state = S_IDLE;
                        n_h     = HASH_IV;
                        n_cnt   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Every word that fills the last buffer slot starts a compression;
        // the sequencer resumes where it left off once the rounds finish.
        if (w_ctl.push) begin
            n_pos = r_pos + 4'd1;
            if (r_pos == POS_LAST) begin
                w_ctl.start = 1'b1;
                n_state     = S_COMP;
                n_ret       = w_after;
            end else begin
                n_state = w_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_h     <= HASH_IV;
            r_ovld  <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_h     <= n_h;
            r_ovld  <= n_ovld;
            r_oidx  <= n_oidx;
        end
    end

    // Input transfers are taken only while the sequencer waits for words.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_item  = r_out;

endmodule

/* hw/rtl/sha_check.sv */
`include "sha256_hash_top_assert.svh"

module sha_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input sha_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sha_pkg::t_out_item o_out_item
);
    import sha_pkg::*;

    // A stalled digest word stays put.
    `SHA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "digest word changed while stalled")

    // Taking the last message item always starts the padding work.
    `SHA_ASSERT_NXT(a_last_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_item.last, o_in_stall, "input not stalled after last item")

    // No new message is taken while a digest word other than the last is waiting to be sent.
    `SHA_ASSERT_IMP(a_out_excl, i_clk, i_rst_n, o_out_valid && !o_out_item.last_word, o_in_stall, "input taken during digest output")

    // Nothing follows the eighth digest word.
    `SHA_ASSERT_NXT(a_out_end, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_out_item.last_word, !o_out_valid, "extra word after final digest word")

endmodule

bind sha256_hash_top sha_check u_check (.*);

/* test/sha256_hash_top_tb.sv */
module sha256_hash_top_tb;

    import sha_pkg::*;

    // The clock period is four units.
    localparam int RESET_CYCLES = 7;
    // The long output hold-off lasts well beyond the time needed to fill the block.
    localparam int HOLD_CYCLES  = 500;
    // Settling time that covers a final padded message plus its eight transfers.
    localparam int SETTLE_CYCLES = 200;
    // Cycles with no transfer on either side before the run is declared hung.
    localparam int STUCK_LIMIT  = 4000;

    // The digest predictor and the store of digest words still owed by the block.
    // Each accepted input item is folded into the running hash state. A last item
    // closes the message and queues its eight digest words.
    class sha256_digest_board;
        t_word       chain[8];
        t_word       block_words[16];
        int unsigned fill;
        logic [31:0] msg_bytes;
        t_out_item   digest_due[$];
        int          mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = HASH_IV[i];
            fill = 0;
            msg_bytes = '0;
        endfunction

        function t_word ror(t_word x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            t_word sched[64];
            t_word v[8];
            t_word s0, s1, t1, t2;
            for (int i = 0; i < 16; i++) sched[i] = block_words[i];
            for (int i = 16; i < 64; i++) begin
                s0 = ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3);
                s1 = ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10);
                sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
            end
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) | (~v[4] & v[6])) + ROUND_K[i] + sched[i];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        function void add_word(t_word w);
            block_words[fill] = w;
            fill++;
            if (fill == 16) begin
                compress();
                fill = 0;
            end
        endfunction

        function void absorb_item(t_in_item it);
            int unsigned nvb;
            t_word       keep;
            t_out_item   dw;
            if (!it.last) begin
                msg_bytes += 32'd4;
                add_word(it.msg_word);
                return;
            end
            nvb = (it.valid_bytes > 3'd4) ? 4 : it.valid_bytes;
            msg_bytes += nvb;
            if (nvb == 4) begin
                add_word(it.msg_word);
                add_word(32'h8000_0000);
            end else begin
                keep = (nvb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nvb));
                add_word((it.msg_word & keep) | (32'h80 << (24 - 8 * nvb)));
            end
            // No room left for the length words: close this block with zeros first.
            if (fill > 14) begin
                while (fill != 0) add_word('0);
            end
            while (fill < 14) add_word('0);
            add_word({29'd0, msg_bytes[31:29]});
            add_word({msg_bytes[28:0], 3'd0});
            for (int i = 0; i < 8; i++) begin
                dw.hash_word  = chain[i];
                dw.word_index = 3'(i);
                dw.last_word  = (i == 7);
                digest_due.push_back(dw);
            end
            restart();
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %h, want %h", what, got, want);
            mismatches++;
        endtask

        task check_word(t_out_item got);
            t_out_item want;
            if (digest_due.size() == 0) begin
                flag_mismatch("digest word with none due", got.hash_word, '0);
                return;
            end
            want = digest_due.pop_front();
            if (got.hash_word !== want.hash_word)
                flag_mismatch("hash_word", got.hash_word, want.hash_word);
            if (got.word_index !== want.word_index)
                flag_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
            if (got.last_word !== want.last_word)
                flag_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
        endtask

        function int words_due();
            return digest_due.size();
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // Idle controls: the percentage of cycles in which the sender holds back and
    // the receiver stalls. They change between phases of the run.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    int   hold_left      = 0;

    sha256_digest_board board = new();

    always #2 i_clk = ~i_clk;

    sha256_hash_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Receiver. A hold request starts a long stall that this process counts down
    // itself; otherwise it stalls at random with the current percentage.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor. Both sides are sampled at the clock edge, before any update that
    // the edge causes. An input transfer feeds the predictor and an output
    // transfer is checked against the oldest digest word due.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.absorb_item(i_in_item);
            if (o_out_valid && !i_out_stall) board.check_word(o_out_item);
        end
    end

    // Watchdog. Any transfer on either side restarts the count.
    initial begin : watchdog
        int stuck;
        stuck = 0;
        wait (i_rst_n === 1'b1);
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_in_item make_item(logic [31:0] w, logic [2:0] vb, logic l);
        t_in_item it;
        it.msg_word    = w;
        it.valid_bytes = vb;
        it.last        = l;
        return it;
    endfunction

    // Offers one item and returns at the edge where it transfers. Valid is lowered
    // only for idle cycles and by drain, so back-to-back items keep it high throughout.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_item  <= {$urandom, 4'($urandom_range(15))};
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Sender pause: valid goes low and the sender waits for every digest word.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.words_due() != 0);
    endtask

    // Lengths cluster around the padding boundary, where the final block may
    // or may not have room for the length words, and around one-block messages.
    function automatic int pick_msg_len();
        int r;
        r = $urandom_range(99);
        if (r < 40) return $urandom_range(5, 1);
        if (r < 70) return $urandom_range(17, 13);
        if (r < 90) return $urandom_range(12, 6);
        return $urandom_range(34, 18);
    endfunction

    // Whole messages with random content and random valid-byte codes. The code
    // on items that are not last should be ignored by the block.
    task automatic send_messages(int n_items, int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = pick_msg_len();
            if (len > max_len) len = max_len;
            if (len > n_items - sent) len = n_items - sent;
            for (int k = 0; k < len; k++)
                send_item(make_item($urandom, 3'($urandom_range(7)), k == len - 1));
            sent += len;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Single-item messages cover the empty message, every
        // valid-byte count, codes above four, and garbage in the unused bytes.
        send_item(make_item(32'hDEAD_BEEF, 3'd0, 1'b1));
        send_item(make_item(32'hFFFF_FFFF, 3'd1, 1'b1));
        send_item(make_item(32'hA5A5_5A5A, 3'd2, 1'b1));
        send_item(make_item(32'h1234_5678, 3'd3, 1'b1));
        send_item(make_item(32'hFFFF_FFFF, 3'd4, 1'b1));
        send_item(make_item(32'h6162_6364, 3'd5, 1'b1));
        send_item(make_item(32'h0000_0000, 3'd7, 1'b1));
        // Valid-byte codes on items that are not last must not matter.
        send_item(make_item(32'hFFFF_FFFF, 3'd0, 1'b0));
        send_item(make_item(32'h0000_0000, 3'd7, 1'b0));
        send_item(make_item(32'h8000_0001, 3'd1, 1'b1));
        // Fourteen full words and a partial last word: the pad lands in slot
        // fourteen, so the length needs a second padding block.
        for (int k = 0; k < 14; k++)
            send_item(make_item($urandom, 3'($urandom_range(7)), 1'b0));
        send_item(make_item($urandom, 3'd2, 1'b1));
        drain();

        // Random part, one phase per idle pattern.
        send_messages(18, 34);
        drain();

        send_idle_pct <= 69;
        send_messages(18, 34);
        drain();

        send_idle_pct  <= 0;
        recv_stall_pct <= 69;
        send_messages(18, 34);
        drain();

        // Back-pressure: the receiver holds off for a long stretch while short
        // messages keep coming, so finished digests back up and the block has
        // to stall its input.
        recv_stall_pct <= 0;
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        send_messages(12, 4);
        drain();

        send_idle_pct  <= 28;
        recv_stall_pct <= 28;
        send_messages(18, 34);
        drain();

        // Let any stray output show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.words_due() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
